// ===== rtl/rids_pkg.sv =====
// Shared types and constants of the row id mapper.
package rids_pkg;

  localparam int unsigned MaxEntries = 1024;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned IdW        = 10;
  localparam int unsigned LenW       = 11;

  localparam logic [2:0] KindAdd    = 3'd0;
  localparam logic [2:0] KindLookup = 3'd1;
  localparam logic [2:0] KindFinal  = 3'd2;
  localparam logic [2:0] KindRdEnt  = 3'd3;
  localparam logic [2:0] KindRdRng  = 3'd4;

  localparam logic [2:0] StNew      = 3'd0;
  localparam logic [2:0] StFound    = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StPhase    = 3'd4;
  localparam logic [2:0] StRange    = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] block_number;
    logic [15:0] row_offset;
    logic [31:0] tenant;
    logic [9:0]  read_index;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  doc_id;
    logic [31:0] out_block;
    logic [15:0] out_offset;
    logic [31:0] out_tenant;
    logic [10:0] range_length;
    logic        ten_order_flag;
    logic [10:0] entry_count;
    logic [10:0] range_count;
  } out_rsp_t;

  // Field order makes a plain vector compare the (tenant, block, offset) order.
  typedef struct packed {
    logic [31:0] ten;
    logic [31:0] blk;
    logic [15:0] off;
  } key_ent_t;

  typedef struct packed {
    logic [31:0]     ten;
    logic [IdxW-1:0] first;
    logic [CntW-1:0] len;
  } rng_ent_t;

  // One word of the slot memory: key and current id of an insertion slot.
  typedef struct packed {
    key_ent_t        key;
    logic [IdxW-1:0] id;
  } slot_ent_t;

  // One word of the rank memory: sorted entry at a rank, range at a range number.
  typedef struct packed {
    key_ent_t ent;
    rng_ent_t rng;
  } rank_ent_t;

  typedef enum logic [9:0] {
    StIdle   = 10'b00_0000_0001,
    StScan   = 10'b00_0000_0010,
    StFLoad  = 10'b00_0000_0100,
    StFLatch = 10'b00_0000_1000,
    StFCmp   = 10'b00_0001_0000,
    StFWr    = 10'b00_0010_0000,
    StRScan  = 10'b00_0100_0000,
    StRFlush = 10'b00_1000_0000,
    StRdWait = 10'b01_0000_0000,
    StDone   = 10'b10_0000_0000
  } state_e;

endpackage

// ===== rtl/row_id_dedup_sort_mapper_top.sv =====
// Row key to dense id mapper with finalize sort and tenant run ranges.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------
//   request | in        | in_valid_i/in_stall_o | in_req_i
//   result  | out       | out_valid_o/out_stall_i | out_rsp_o
//
// Add and lookup scan the slot memory one slot a cycle.
// Finalize ranks each entry by a full pass over the slot memory.
// Both memories are read through a registered read port.
// Reset clears the state, the entry and range counts and the flags only; memories hold no reset value.
// A stalled result holds in the output register; the next request is taken
// meanwhile and its result waits in the done state.
module row_id_dedup_sort_mapper_top
  import rids_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  // Slot memory: key and id by insertion slot. Rank memory: sorted copy by
  // rank in one field, range list by range number in the other.
  slot_ent_t slot_mem [MaxEntries];
  rank_ent_t rank_mem [MaxEntries];

  state_e state_q, state_d;
  in_req_t req_q, req_d;
  out_rsp_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [CntW-1:0] held_q, held_d, ranges_q, ranges_d;
  logic fin_q, fin_d, ord_q, ord_d;
  logic [CntW-1:0] cnt_q, cnt_d, icnt_q, icnt_d, rank_q, rank_d;
  logic [CntW-1:0] seg_base_q, seg_base_d;
  logic [31:0] run_ten_q, run_ten_d;
  logic pend_q, pend_d;
  key_ent_t cur_q, cur_d;

  logic [IdxW-1:0] slot_ra, slot_wa, rank_ra, rank_wa;
  logic slot_we, srt_we, rng_we;
  slot_ent_t slot_wd, slot_rd_q;
  rank_ent_t rank_rd_q;
  key_ent_t srt_wd;
  rng_ent_t rng_wd;
  logic [CntW-1:0] rnk;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign rnk         = cnt_q - CntW'(1);

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd_q <= slot_mem[slot_ra];
  end

  // Sorted entries and ranges are never written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (srt_we) rank_mem[rank_wa].ent <= srt_wd;
    if (rng_we) rank_mem[rank_wa].rng <= rng_wd;
    rank_rd_q <= rank_mem[rank_ra];
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    held_d      = held_q;
    ranges_d    = ranges_q;
    fin_d       = fin_q;
    ord_d       = ord_q;
    cnt_d       = cnt_q;
    icnt_d      = icnt_q;
    rank_d      = rank_q;
    seg_base_d  = seg_base_q;
    run_ten_d   = run_ten_q;
    pend_d      = pend_q;
    cur_d       = cur_q;
    slot_ra = cnt_q[IdxW-1:0];
    rank_ra = cnt_q[IdxW-1:0];
    slot_we = 1'b0; slot_wa = held_q[IdxW-1:0];
    slot_wd = '{key: '{ten: req_q.tenant, blk: req_q.block_number,
                       off: req_q.row_offset},
                id: held_q[IdxW-1:0]};
    srt_we = 1'b0; rng_we = 1'b0;
    rank_wa = ranges_q[IdxW-1:0];
    srt_wd = cur_q;
    rng_wd = '{ten: run_ten_q, first: seg_base_q[IdxW-1:0],
               len: rnk - seg_base_q};

    // Drop the result once taken.
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          req_d        = in_req_i;
          res_d        = '0;
          res_d.status = StPhase;
          pend_d       = 1'b0;
          cnt_d        = '0;
          state_d      = StDone;
          case (in_req_i.kind)
            KindAdd: begin
              if (!fin_q) state_d = StScan;
            end
            KindLookup: state_d = StScan;
            KindFinal: begin
              if (!fin_q) begin
                fin_d        = 1'b1;
                ord_d        = 1'b0;
                ranges_d     = '0;
                res_d.status = StNew;
                icnt_d       = '0;
                if (held_q != '0) state_d = StFLoad;
              end
            end
            KindRdEnt: begin
              rank_ra = in_req_i.read_index[IdxW-1:0];
              if (fin_q) begin
                if (32'(in_req_i.read_index) >= 32'(held_q)) res_d.status = StRange;
                else state_d = StRdWait;
              end
            end
            KindRdRng: begin
              rank_ra = in_req_i.read_index[IdxW-1:0];
              if (fin_q) begin
                if (32'(in_req_i.read_index) >= 32'(ranges_q)) res_d.status = StRange;
                else state_d = StRdWait;
              end
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        if (pend_q && slot_rd_q.key.blk == req_q.block_number
            && slot_rd_q.key.off == req_q.row_offset) begin
          res_d.status = StFound;
          res_d.doc_id = IdW'(slot_rd_q.id);
          state_d      = StDone;
        end else if (cnt_q == held_q) begin
          state_d = StDone;
          if (req_q.kind == KindLookup) begin
            res_d.status = StNotFound;
          end else if (32'(held_q) >= MaxEntries) begin
            res_d.status = StFull;
          end else begin
            slot_we      = 1'b1;
            held_d       = held_q + CntW'(1);
            res_d.status = StNew;
            res_d.doc_id = IdW'(held_q);
          end
        end else begin
          cnt_d  = cnt_q + CntW'(1);
          pend_d = 1'b1;
        end
      end
      StFLoad: begin
        slot_ra = icnt_q[IdxW-1:0];
        state_d = StFLatch;
      end
      StFLatch: begin
        cur_d   = slot_rd_q.key;
        if (slot_rd_q.key.ten != '0) ord_d = 1'b1;
        rank_d  = '0;
        cnt_d   = '0;
        pend_d  = 1'b0;
        state_d = StFCmp;
      end
      StFCmp: begin
        // Count entries that order before the current one.
        if (pend_q && (slot_rd_q.key < cur_q)) rank_d = rank_q + CntW'(1);
        if (cnt_q == held_q) begin
          state_d = StFWr;
        end else begin
          cnt_d  = cnt_q + CntW'(1);
          pend_d = 1'b1;
        end
      end
      StFWr: begin
        // Write back the key unchanged with its new id.
        slot_we = 1'b1;
        slot_wa = icnt_q[IdxW-1:0];
        slot_wd = '{key: cur_q, id: rank_q[IdxW-1:0]};
        srt_we  = 1'b1;
        rank_wa = rank_q[IdxW-1:0];
        icnt_d  = icnt_q + CntW'(1);
        if (icnt_q + CntW'(1) == held_q) begin
          cnt_d  = '0;
          pend_d = 1'b0;
          state_d = ord_q ? StRScan : StDone;
        end else begin
          state_d = StFLoad;
        end
      end
      StRScan: begin
        if (pend_q) begin
          if (rnk == '0) begin
            run_ten_d  = rank_rd_q.ent.ten;
            seg_base_d = '0;
          end else if (rank_rd_q.ent.ten != run_ten_q) begin
            if (run_ten_q != '0) begin
              rng_we   = 1'b1;
              ranges_d = ranges_q + CntW'(1);
            end
            seg_base_d = rnk;
            run_ten_d  = rank_rd_q.ent.ten;
          end
        end
        if (cnt_q == held_q) begin
          state_d = StRFlush;
        end else begin
          cnt_d  = cnt_q + CntW'(1);
          pend_d = 1'b1;
        end
      end
      StRFlush: begin
        rng_wd.len = held_q - seg_base_q;
        if (run_ten_q != '0) begin
          rng_we   = 1'b1;
          ranges_d = ranges_q + CntW'(1);
        end
        state_d = StDone;
      end
      StRdWait: begin
        res_d.status = StNew;
        if (req_q.kind == KindRdEnt) begin
          res_d.doc_id     = req_q.read_index;
          res_d.out_block  = rank_rd_q.ent.blk;
          res_d.out_offset = rank_rd_q.ent.off;
          res_d.out_tenant = rank_rd_q.ent.ten;
        end else begin
          res_d.doc_id       = IdW'(rank_rd_q.rng.first);
          res_d.out_tenant   = rank_rd_q.rng.ten;
          res_d.range_length = LenW'(rank_rd_q.rng.len);
        end
        state_d = StDone;
      end
      StDone: begin
        // Advance only into a free output register.
        if (!out_valid_q || !out_stall_i) begin
          out_d                = res_q;
          out_d.ten_order_flag = ord_q;
          out_d.entry_count    = LenW'(held_q);
          out_d.range_count    = LenW'(ranges_q);
          out_valid_d          = 1'b1;
          state_d              = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      held_q      <= '0;
      ranges_q    <= '0;
      fin_q       <= 1'b0;
      ord_q       <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      held_q      <= held_d;
      ranges_q    <= ranges_d;
      fin_q       <= fin_d;
      ord_q       <= ord_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    out_q      <= out_d;
    cnt_q      <= cnt_d;
    icnt_q     <= icnt_d;
    rank_q     <= rank_d;
    seg_base_q <= seg_base_d;
    run_ten_q  <= run_ten_d;
    cur_q      <= cur_d;
  end

  a_held_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(held_q) <= MaxEntries) else $error("held count beyond capacity");

  a_ranges_le_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ranges_q <= held_q) else $error("more ranges than entries");

  a_held_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> $stable(held_q)) else $error("entry count moved after finalize");

  a_ord_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ord_q |-> fin_q) else $error("tenant order flag without finalize");

endmodule
